### rtl/alle_pkg.sv
// Shared types and codes of the array linked list engine.
// Used by the controller, the datapath and the top level; depends on nothing.

package alle_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_REINIT = 2'd3
	} alle_action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_BAD_LOC   = 2'd3
	} alle_status_t;

	typedef enum logic [3:0] {
		UOP_NONE,
		UOP_LOAD,
		UOP_CHECK,
		UOP_SWEEP,
		UOP_RD_FREE,
		UOP_TAKE_FREE,
		UOP_LINK_AFTER,
		UOP_LINK_LOC,
		UOP_DEL_RD,
		UOP_DEL_LINK,
		UOP_DEL_FREE,
		UOP_SRCH_RD,
		UOP_SRCH_CMP,
		UOP_EMIT
	} alle_uop_t;

	typedef struct packed {
		alle_action_t action;
		alle_status_t err;
		logic         loc_none;
		logic         cur_live;
		logic         match;
		logic         sweep_last;
		logic         out_busy;
	} alle_sts_t;

endpackage

### rtl/alle_req_if.sv
// Request channel of the array linked list engine.
// Carries one request word with a valid and ready handshake; no dependencies.

interface alle_req_if #(
	parameter int IDX_W = 7
) ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              action;
	logic signed [IDX_W-1:0] location;
	logic signed [IDX_W-1:0] prev_location;
	logic signed [31:0]      value;

	modport source(output valid, action, location, prev_location, value, input ready);
	modport sink(input valid, action, location, prev_location, value, output ready);
endinterface

### rtl/alle_rsp_if.sv
// Response channel of the array linked list engine.
// Carries one result word with a valid and ready handshake; no dependencies.

interface alle_rsp_if #(
	parameter int IDX_W = 7
) ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic signed [IDX_W-1:0] node_index;
	logic signed [IDX_W-1:0] list_head;

	modport source(output valid, status, node_index, list_head, input ready);
	modport sink(input valid, status, node_index, list_head, output ready);
endinterface

### rtl/alle_ram.sv
// Generic simple dual port RAM with one write port and one registered read port.
// Used for the node value store and the link store; no dependencies.

module alle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/alle_ctrl.sv
// Controller state machine of the array linked list engine.
// Issues at most one micro-operation per cycle to the datapath; depends on alle_pkg.

module alle_ctrl
	import alle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  alle_sts_t sts,
	output alle_uop_t uop
);
	typedef enum logic [3:0] {
		S_RST_SWEEP,
		S_IDLE,
		S_CHECK,
		S_INS_RD,
		S_INS_TAKE,
		S_INS_AFTER,
		S_INS_LOC,
		S_DEL_RD,
		S_DEL_LINK,
		S_DEL_FREE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SWEEP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		uop      = UOP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_RST_SWEEP: begin
				uop = UOP_SWEEP;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					uop     = UOP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				uop = UOP_CHECK;
				if (sts.err != ST_OK) begin
					state_d = S_DONE;
				end else begin
					unique case (sts.action)
						ACT_INSERT: state_d = S_INS_RD;
						ACT_DELETE: state_d = S_DEL_RD;
						ACT_SEARCH: state_d = S_SRCH_RD;
						ACT_REINIT: state_d = S_SWEEP;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_INS_RD: begin
				uop     = UOP_RD_FREE;
				state_d = S_INS_TAKE;
			end
			S_INS_TAKE: begin
				uop     = UOP_TAKE_FREE;
				state_d = sts.loc_none ? S_DONE : S_INS_AFTER;
			end
			S_INS_AFTER: begin
				uop     = UOP_LINK_AFTER;
				state_d = S_INS_LOC;
			end
			S_INS_LOC: begin
				uop     = UOP_LINK_LOC;
				state_d = S_DONE;
			end
			S_DEL_RD: begin
				uop     = UOP_DEL_RD;
				state_d = S_DEL_LINK;
			end
			S_DEL_LINK: begin
				uop     = UOP_DEL_LINK;
				state_d = S_DEL_FREE;
			end
			S_DEL_FREE: begin
				uop     = UOP_DEL_FREE;
				state_d = S_DONE;
			end
			S_SRCH_RD: begin
				if (sts.cur_live) begin
					uop     = UOP_SRCH_RD;
					state_d = S_SRCH_CMP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SRCH_CMP: begin
				uop     = UOP_SRCH_CMP;
				state_d = sts.match ? S_DONE : S_SRCH_RD;
			end
			S_SWEEP: begin
				uop = UOP_SWEEP;
				if (sts.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					uop     = UOP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### rtl/alle_dpath.sv
// Datapath of the array linked list engine: request and pointer registers,
// the value and link stores, and the result register. Depends on alle_pkg and alle_ram.

module alle_dpath
	import alle_pkg::*;
#(
	parameter int NODE_COUNT = 64,
	parameter int AW         = $clog2(NODE_COUNT),
	parameter int IDX_W      = AW + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  alle_uop_t               uop,
	output alle_sts_t               sts,
	input  logic [1:0]              in_action,
	input  logic signed [IDX_W-1:0] in_location,
	input  logic signed [IDX_W-1:0] in_prev_location,
	input  logic signed [31:0]      in_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              out_status,
	output logic signed [IDX_W-1:0] out_node_index,
	output logic signed [IDX_W-1:0] out_list_head
);
	localparam logic [AW:0]        NC      = (AW + 1)'(NODE_COUNT);
	localparam logic [AW-1:0]      LAST    = AW'(NODE_COUNT - 1);
	localparam logic [IDX_W-1:0]   NO_NODE = '1;

	function automatic logic is_node(input logic [IDX_W-1:0] x);
		is_node = !x[IDX_W-1] && ({1'b0, x[AW-1:0]} < NC);
	endfunction

	alle_action_t      action_q;
	logic [IDX_W-1:0]  loc_q;
	logic [IDX_W-1:0]  prev_q;
	logic [31:0]       value_q;
	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  free_q;
	logic [IDX_W-1:0]  fresh_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  found_q;
	logic [AW:0]       cnt_q;
	alle_status_t      res_q;
	alle_status_t      err;

	logic              out_valid_q;
	alle_status_t      out_status_q;
	logic [IDX_W-1:0]  out_node_q;
	logic [IDX_W-1:0]  out_head_q;

	logic              link_we;
	logic [AW-1:0]     link_waddr;
	logic [IDX_W-1:0]  link_wdata;
	logic [AW-1:0]     raddr;
	logic [IDX_W-1:0]  rd_link;
	logic              val_we;
	logic [31:0]       rd_value;
	logic              sweep_last;

	always_comb begin
		err = ST_OK;
		unique case (action_q)
			ACT_INSERT: begin
				if (!is_node(free_q)) begin
					err = ST_OVERFLOW;
				end else if (loc_q != NO_NODE && !is_node(loc_q)) begin
					err = ST_BAD_LOC;
				end
			end
			ACT_DELETE: begin
				if (!is_node(head_q)) begin
					err = ST_UNDERFLOW;
				end else if (!is_node(loc_q) || (prev_q != NO_NODE && !is_node(prev_q))) begin
					err = ST_BAD_LOC;
				end
			end
			default: err = ST_OK;
		endcase
	end

	assign sweep_last = (cnt_q[AW-1:0] == LAST);

	always_comb begin
		sts.action     = action_q;
		sts.err        = err;
		sts.loc_none   = (loc_q == NO_NODE);
		sts.cur_live   = is_node(cur_q) && (cnt_q < NC);
		sts.match      = (rd_value == value_q);
		sts.sweep_last = sweep_last;
		sts.out_busy   = out_valid_q && !out_ready;
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = fresh_q[AW-1:0];
		link_wdata = rd_link;
		raddr      = cur_q[AW-1:0];
		val_we     = 1'b0;
		unique case (uop)
			UOP_SWEEP: begin
				link_we    = 1'b1;
				link_waddr = cnt_q[AW-1:0];
				link_wdata = sweep_last ? NO_NODE : IDX_W'({1'b0, cnt_q[AW-1:0]} + 1'b1);
			end
			UOP_RD_FREE: begin
				raddr  = free_q[AW-1:0];
				val_we = 1'b1;
			end
			UOP_TAKE_FREE: begin
				raddr      = loc_q[AW-1:0];
				link_we    = (loc_q == NO_NODE);
				link_wdata = head_q;
			end
			UOP_LINK_AFTER: begin
				link_we = 1'b1;
			end
			UOP_LINK_LOC: begin
				link_we    = 1'b1;
				link_waddr = loc_q[AW-1:0];
				link_wdata = fresh_q;
			end
			UOP_DEL_RD: begin
				raddr = (prev_q == NO_NODE) ? head_q[AW-1:0] : loc_q[AW-1:0];
			end
			UOP_DEL_LINK: begin
				link_we    = (prev_q != NO_NODE);
				link_waddr = prev_q[AW-1:0];
			end
			UOP_DEL_FREE: begin
				link_we    = 1'b1;
				link_waddr = loc_q[AW-1:0];
				link_wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	alle_ram #(
		.WIDTH(IDX_W),
		.DEPTH(NODE_COUNT)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(raddr),
		.rdata(rd_link)
	);

	alle_ram #(
		.WIDTH(32),
		.DEPTH(NODE_COUNT)
	) u_value_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(free_q[AW-1:0]),
		.wdata(value_q),
		.raddr(raddr),
		.rdata(rd_value)
	);

	always_ff @(posedge clk) begin
		unique case (uop)
			UOP_LOAD: begin
				action_q <= alle_action_t'(in_action);
				loc_q    <= in_location;
				prev_q   <= in_prev_location;
				value_q  <= in_value;
				found_q  <= NO_NODE;
			end
			UOP_CHECK: begin
				res_q <= err;
				cur_q <= head_q;
			end
			UOP_RD_FREE: begin
				fresh_q <= free_q;
			end
			UOP_TAKE_FREE: begin
				found_q <= fresh_q;
			end
			UOP_SRCH_CMP: begin
				if (rd_value == value_q) begin
					found_q <= cur_q;
				end else begin
					cur_q <= rd_link;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= NO_NODE;
			free_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (uop)
				UOP_LOAD: begin
					cnt_q <= '0;
				end
				UOP_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (sweep_last) begin
						head_q <= NO_NODE;
						free_q <= '0;
					end
				end
				UOP_TAKE_FREE: begin
					free_q <= rd_link;
					if (loc_q == NO_NODE) begin
						head_q <= fresh_q;
					end
				end
				UOP_DEL_LINK: begin
					if (prev_q == NO_NODE) begin
						head_q <= rd_link;
					end
				end
				UOP_DEL_FREE: begin
					free_q <= loc_q;
				end
				UOP_SRCH_CMP: begin
					cnt_q <= cnt_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (uop == UOP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (uop == UOP_EMIT) begin
			out_status_q <= res_q;
			out_node_q   <= found_q;
			out_head_q   <= head_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_node_index = out_node_q;
	assign out_list_head  = out_head_q;
endmodule

### rtl/array_linked_list_engine_unit.sv
// Top level of the array linked list engine: controller and datapath.
// Depends on alle_pkg, alle_req_if, alle_rsp_if, alle_ctrl and alle_dpath.
//
//   Port   Direction  Word
//   req    in         action, location, prev_location, value
//   rsp    out        status, node_index, list_head
//
// One request is in work at a time; the link store has one write and one registered read port.
// Insert links a free node at the head or after a given node; delete unlinks a node
// and returns it to the free list; a rejected request goes straight to its result.
// Search walks the list from the head and stops at the first match or at its end.
// Reinitialize rebuilds the link chain over every node.
// After reset the link chain is rebuilt before req is ready.
// A result waiting on rsp holds the next request only when that one finishes.

module array_linked_list_engine_unit
	import alle_pkg::*;
#(
	parameter int NODE_COUNT = 64
) (
	input logic         clk,
	input logic         arst_n,
	alle_req_if.sink    req,
	alle_rsp_if.source  rsp
);
	localparam int AW    = $clog2(NODE_COUNT);
	localparam int IDX_W = AW + 1;

	alle_uop_t uop;
	alle_sts_t sts;

	alle_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.sts     (sts),
		.uop     (uop)
	);

	alle_dpath #(
		.NODE_COUNT(NODE_COUNT),
		.AW        (AW),
		.IDX_W     (IDX_W)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.uop             (uop),
		.sts             (sts),
		.in_action       (req.action),
		.in_location     (req.location),
		.in_prev_location(req.prev_location),
		.in_value        (req.value),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_node_index  (rsp.node_index),
		.out_list_head   (rsp.list_head)
	);
endmodule
